>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands used by ght_ctrl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`define ASSERT_IMPLIES(label, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);
`else
`define ASSERT_NEVER(label, expr, msg)
`define ASSERT_IMPLIES(label, a, b, msg)
`endif
`endif

>>> design/ght_pkg.sv
// ----------------------------------------------------------------------------
// ght_pkg
// types, codes and helpers of the group probed hash table
// ----------------------------------------------------------------------------
package ght_pkg;

  localparam int GROUP_SIZE = 16;
  localparam int GROUP_LOG  = 4;
  localparam int TAG_W      = 8;

  localparam logic [TAG_W-1:0] TAG_EMPTY   = 8'hFF;
  localparam logic [TAG_W-1:0] TAG_DELETED = 8'hFE;

  typedef enum logic [2:0] {
    K_LOOKUP      = 3'd0,
    K_INSERT      = 3'd1,
    K_ERASE       = 3'd2,
    K_CLEAR       = 3'd3,
    K_FIND_OR_ADD = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ST_FOUND     = 3'd0,
    ST_INSERTED  = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_ERASED    = 3'd3,
    ST_FULL      = 3'd4,
    ST_CLEARED   = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_PROBE,
    S_RD2,
    S_WR,
    S_CLR_RD,
    S_CLR_WR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic rd;
    logic wr_tag;
    logic wr_kv;
  } mem_cmd_t;

  function automatic logic [TAG_W-1:0] tag_of(input logic [31:0] h);
    logic [TAG_W-1:0] t;
    t = h[14:7];
    if (t >= TAG_DELETED) begin
      t = TAG_DELETED - 8'd1;
    end
    return t;
  endfunction

endpackage

>>> design/ght_req_if.sv
// ----------------------------------------------------------------------------
// ght_req_if
// request channel of the hash table
// ----------------------------------------------------------------------------
interface ght_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] key;
  logic [31:0] hash;
  logic [31:0] value;

  modport source (output valid, kind, key, hash, value, input ready);
  modport sink (input valid, kind, key, hash, value, output ready);
endinterface

>>> design/ght_rsp_if.sv
// ----------------------------------------------------------------------------
// ght_rsp_if
// result channel of the hash table
// ----------------------------------------------------------------------------
interface ght_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [9:0]  slot;
  logic [31:0] found_value;
  logic [10:0] entry_count;

  modport source (output valid, status, slot, found_value, entry_count, input ready);
  modport sink (input valid, status, slot, found_value, entry_count, output ready);
endinterface

>>> design/ght_store.sv
// ----------------------------------------------------------------------------
// ght_store
// group wide tag, key and value memories, one row per group of sixteen slots
// ----------------------------------------------------------------------------
module ght_store #(
  parameter int SLOTS      = 1024,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic                                         clk,
  input  ght_pkg::mem_cmd_t                            cmd,
  input  logic [((SLOTS/16 > 1) ? $clog2(SLOTS/16) : 1)-1:0] addr,
  input  logic [16*8-1:0]                              wtag,
  input  logic [16*KEY_BITS-1:0]                       wkey,
  input  logic [16*VALUE_BITS-1:0]                     wval,
  output logic [16*8-1:0]                              rtag,
  output logic [16*KEY_BITS-1:0]                       rkey,
  output logic [16*VALUE_BITS-1:0]                     rval
);
  import ght_pkg::*;

  localparam int GROUPS = SLOTS / GROUP_SIZE;

  logic [GROUP_SIZE*TAG_W-1:0]      tag_mem [GROUPS];
  logic [GROUP_SIZE*KEY_BITS-1:0]   key_mem [GROUPS];
  logic [GROUP_SIZE*VALUE_BITS-1:0] val_mem [GROUPS];

  always_ff @(posedge clk) begin
    if (cmd.wr_tag) begin
      tag_mem[addr] <= wtag;
    end
    if (cmd.rd) begin
      rtag <= tag_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_kv) begin
      key_mem[addr] <= wkey;
      val_mem[addr] <= wval;
    end
    if (cmd.rd) begin
      rkey <= key_mem[addr];
      rval <= val_mem[addr];
    end
  end

endmodule

>>> design/ght_ctrl.sv
// ----------------------------------------------------------------------------
// ght_ctrl
// probe sequencer: group scan, read modify write, clear and reset passes
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ght_ctrl #(
  parameter int SLOTS      = 1024,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic                                         clk,
  input  logic                                         rst,
  ght_req_if.sink                                      req,
  input  logic [10:0]                                  max_fill,
  input  logic                                         out_free,
  output logic                                         done,
  output ght_pkg::status_t                             res_status,
  output logic [9:0]                                   res_slot,
  output logic [31:0]                                  res_value,
  output logic [10:0]                                  res_count,
  output ght_pkg::mem_cmd_t                            cmd,
  output logic [((SLOTS/16 > 1) ? $clog2(SLOTS/16) : 1)-1:0] addr,
  output logic [16*8-1:0]                              wtag,
  output logic [16*KEY_BITS-1:0]                       wkey,
  output logic [16*VALUE_BITS-1:0]                     wval,
  input  logic [16*8-1:0]                              rtag,
  input  logic [16*KEY_BITS-1:0]                       rkey,
  input  logic [16*VALUE_BITS-1:0]                     rval
);
  import ght_pkg::*;

  localparam int GROUPS = SLOTS / GROUP_SIZE;
  localparam int GAW    = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int SW     = GAW + GROUP_LOG;
  localparam logic [GAW-1:0] GMASK = GAW'(GROUPS - 1);

  state_t                  state, state_next;
  kind_t                   kind_r;
  logic [KEY_BITS-1:0]     key_r;
  logic [VALUE_BITS-1:0]   val_r;
  logic [TAG_W-1:0]        tag_r;
  logic [GAW-1:0]          g, n, row_r;
  logic                    fd_valid;
  logic [SW-1:0]           fd_slot, tgt, slot_r;
  status_t                 status_r;
  logic [VALUE_BITS-1:0]   fval_r;
  logic [10:0]             live;

  logic [GROUP_SIZE-1:0]   hit_m, del_m, emp_m;
  logic [GROUP_LOG-1:0]    hit_l, del_l, emp_l;
  logic                    any_hit, any_del, any_emp, last;
  logic                    fd_new_valid, free_ok, full_chk, is_add, scan_end;
  logic [SW-1:0]           fd_new, free_slot;
  logic [GAW-1:0]          g_next, g0;
  logic [27:0]             hg;
  logic [63:0]             k64, v64, fv64;
  logic [31:0]             s32;
  logic [GROUP_LOG-1:0]    tgt_l;

  // per lane analysis of the group row
  always_comb begin
    hit_l = '0;
    del_l = '0;
    emp_l = '0;
    for (int i = 0; i < GROUP_SIZE; i++) begin
      hit_m[i] = (rtag[i*TAG_W +: TAG_W] == tag_r) && (rkey[i*KEY_BITS +: KEY_BITS] == key_r);
      del_m[i] = (rtag[i*TAG_W +: TAG_W] == TAG_DELETED);
      emp_m[i] = (rtag[i*TAG_W +: TAG_W] == TAG_EMPTY);
    end
    for (int i = GROUP_SIZE - 1; i >= 0; i--) begin
      if (hit_m[i]) hit_l = GROUP_LOG'(i);
      if (del_m[i]) del_l = GROUP_LOG'(i);
      if (emp_m[i]) emp_l = GROUP_LOG'(i);
    end
  end

  assign any_hit      = |hit_m;
  assign any_del      = |del_m;
  assign any_emp      = |emp_m;
  assign last         = (n == GMASK);
  assign scan_end     = any_emp || last;
  assign g_next       = (g + 1'b1) & GMASK;
  assign fd_new_valid = fd_valid || any_del;
  assign fd_new       = fd_valid ? fd_slot : {g, del_l};
  assign free_ok      = any_emp || fd_new_valid;
  assign free_slot    = fd_new_valid ? fd_new : {g, emp_l};
  assign full_chk     = ({1'b0, live} + 12'd1) > {1'b0, max_fill};
  assign is_add       = (kind_r == K_INSERT) || (kind_r == K_FIND_OR_ADD);
  assign hg           = req.hash[31:4];
  assign g0           = GAW'(hg & 28'(GROUPS - 1));
  assign k64          = 64'(req.key);
  assign v64          = 64'(req.value);
  assign tgt_l        = tgt[GROUP_LOG-1:0];

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT: begin
        if (row_r == GMASK) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req.valid) begin
          priority case (req.kind)
            K_CLEAR: state_next = S_CLR_RD;
            K_LOOKUP, K_INSERT, K_ERASE, K_FIND_OR_ADD: state_next = S_PROBE;
            default: state_next = S_DONE;
          endcase
        end
      end
      S_PROBE: begin
        if (any_hit) begin
          state_next = (kind_r == K_ERASE) ? S_RD2 : S_DONE;
        end else if (scan_end) begin
          state_next = (is_add && free_ok && !full_chk) ? S_RD2 : S_DONE;
        end
      end
      S_RD2:    state_next = S_WR;
      S_WR:     state_next = S_DONE;
      S_CLR_RD: state_next = S_CLR_WR;
      S_CLR_WR: state_next = (row_r == GMASK) ? S_DONE : S_CLR_RD;
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default:  state_next = S_INIT;
    endcase
  end

  // memory commands and handshake
  always_comb begin
    cmd       = '0;
    addr      = g;
    wtag      = rtag;
    wkey      = rkey;
    wval      = rval;
    req.ready = 1'b0;
    done      = 1'b0;
    unique case (state)
      S_INIT: begin
        cmd.wr_tag = 1'b1;
        addr       = row_r;
        wtag       = {GROUP_SIZE{TAG_EMPTY}};
      end
      S_IDLE: begin
        req.ready = 1'b1;
        cmd.rd    = req.valid;
        addr      = g0;
      end
      S_PROBE: begin
        cmd.rd = !any_hit && !scan_end;
        addr   = g_next;
      end
      S_RD2: begin
        cmd.rd = 1'b1;
        addr   = tgt[SW-1:GROUP_LOG];
      end
      S_WR: begin
        cmd.wr_tag = 1'b1;
        cmd.wr_kv  = (status_r == ST_INSERTED);
        addr       = tgt[SW-1:GROUP_LOG];
        if (status_r == ST_INSERTED) begin
          wtag[tgt_l*TAG_W +: TAG_W] = tag_r;
        end else begin
          wtag[tgt_l*TAG_W +: TAG_W] = TAG_DELETED;
        end
        wkey[tgt_l*KEY_BITS +: KEY_BITS]     = key_r;
        wval[tgt_l*VALUE_BITS +: VALUE_BITS] = val_r;
      end
      S_CLR_RD: begin
        cmd.rd = 1'b1;
        addr   = row_r;
      end
      S_CLR_WR: begin
        cmd.wr_tag = 1'b1;
        addr       = row_r;
        for (int i = 0; i < GROUP_SIZE; i++) begin
          if (rtag[i*TAG_W +: TAG_W] < TAG_DELETED) wtag[i*TAG_W +: TAG_W] = TAG_EMPTY;
        end
      end
      S_DONE: done = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      row_r <= '0;
      live  <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        S_INIT: row_r <= (row_r + 1'b1) & GMASK;
        S_WR: begin
          if (status_r == ST_INSERTED) begin
            live <= live + 11'd1;
          end else if (live != 11'd0) begin
            live <= live - 11'd1;
          end
        end
        S_CLR_WR: begin
          row_r <= (row_r + 1'b1) & GMASK;
          live  <= '0;
        end
        default: ;
      endcase
    end
  end

  // request and probe bookkeeping
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          kind_r   <= kind_t'(req.kind);
          key_r    <= k64[KEY_BITS-1:0];
          val_r    <= (req.kind == K_FIND_OR_ADD) ? '0 : v64[VALUE_BITS-1:0];
          tag_r    <= tag_of(req.hash);
          g        <= g0;
          n        <= '0;
          fd_valid <= 1'b0;
          slot_r   <= '0;
          fval_r   <= '0;
          status_r <= (req.kind == K_CLEAR) ? ST_CLEARED : ST_NOT_FOUND;
        end
      end
      S_PROBE: begin
        fd_valid <= fd_new_valid;
        fd_slot  <= fd_new;
        if (any_hit) begin
          slot_r   <= {g, hit_l};
          tgt      <= {g, hit_l};
          fval_r   <= rval[hit_l*VALUE_BITS +: VALUE_BITS];
          status_r <= (kind_r == K_ERASE) ? ST_ERASED : ST_FOUND;
        end else if (scan_end) begin
          if (is_add) begin
            if (!free_ok || full_chk) begin
              status_r <= ST_FULL;
            end else begin
              status_r <= ST_INSERTED;
              tgt      <= free_slot;
              slot_r   <= free_slot;
              fval_r   <= val_r;
            end
          end
        end else begin
          g <= g_next;
          n <= n + 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign fv64       = 64'(fval_r);
  assign s32        = 32'(slot_r);
  assign res_status = status_r;
  assign res_slot   = s32[9:0];
  assign res_value  = fv64[31:0];
  assign res_count  = live;

  `ASSERT_NEVER(a_rd_wr_clash, cmd.rd && (cmd.wr_tag || cmd.wr_kv), "read and write in one cycle")
  `ASSERT_IMPLIES(a_insert_room, cmd.wr_kv, cmd.wr_tag && (live < max_fill), "insert past fill limit")
  `ASSERT_IMPLIES(a_rmw_order, state == S_WR, $past(state) == S_RD2, "write without row read")

endmodule

>>> design/group_probed_hash_table_top.sv
// ----------------------------------------------------------------------------
// group_probed_hash_table_top
// open addressing key/value table with sixteen tag group probing
// ----------------------------------------------------------------------------
// requests come in on req (kind, key, hash, value) by valid/ready; one result
// per request leaves on rsp (status, slot, found_value, entry_count).
// the user writes max_fill through cfg_wr_en / cfg_wr_data only while the block
// is idle; the block itself does not enforce it.
// one request at a time: req.ready is high only while the sequencer waits.
// a request scans group rows, one group row per cycle out of the single ported
// group memory; an add or erase adds a row read modify write; clear reads and
// rewrites every tag row. the result sits in an output register, so the next
// request is taken while it waits; if rsp is stalled the block holds the next
// result until it goes. after reset a pass writes every tag row empty, with
// req.ready low; max_fill resets to 768 and the entry count to zero.
// ----------------------------------------------------------------------------
module group_probed_hash_table_top #(
  parameter int SLOTS      = 1024,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [10:0] cfg_wr_data,
  ght_req_if.sink     req,
  ght_rsp_if.source   rsp
);
  import ght_pkg::*;

  localparam int GROUPS = SLOTS / GROUP_SIZE;
  localparam int GAW    = (GROUPS > 1) ? $clog2(GROUPS) : 1;

  logic [10:0]                      max_fill;
  logic                             out_free, done;
  status_t                          res_status;
  logic [9:0]                       res_slot;
  logic [31:0]                      res_value;
  logic [10:0]                      res_count;
  mem_cmd_t                         cmd;
  logic [GAW-1:0]                   addr;
  logic [GROUP_SIZE*TAG_W-1:0]      wtag, rtag;
  logic [GROUP_SIZE*KEY_BITS-1:0]   wkey, rkey;
  logic [GROUP_SIZE*VALUE_BITS-1:0] wval, rval;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_fill <= 11'd768;
    end else if (cfg_wr_en) begin
      max_fill <= cfg_wr_data;
    end
  end

  assign out_free = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (done) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      rsp.status      <= res_status;
      rsp.slot        <= res_slot;
      rsp.found_value <= res_value;
      rsp.entry_count <= res_count;
    end
  end

  ght_ctrl #(
    .SLOTS(SLOTS), .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)
  ) u_ctrl (
    .clk, .rst, .req, .max_fill, .out_free, .done,
    .res_status, .res_slot, .res_value, .res_count,
    .cmd, .addr, .wtag, .wkey, .wval, .rtag, .rkey, .rval
  );

  ght_store #(
    .SLOTS(SLOTS), .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)
  ) u_store (
    .clk, .cmd, .addr, .wtag, .wkey, .wval, .rtag, .rkey, .rval
  );

endmodule

>>> dv/group_probed_hash_table_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// group_probed_hash_table_top_tb
// self checking bench for the group probed hash table: a directed table of
// requests, mostly with typed expected results, random traffic on a small
// key pool with colliding hashes, and a fill up to the limit from one start
// group; the other results are checked against a table predictor
// ----------------------------------------------------------------------------
module group_probed_hash_table_top_tb;
  import ght_pkg::*;

  localparam int NSLOTS   = 1024;
  localparam int NGROUPS  = NSLOTS / GROUP_SIZE;
  localparam int NO_SLOT  = -1;
  localparam int WD_LIMIT = 20000;
  localparam logic [2:0] K_SPARE_LO = 3'd5;
  localparam logic [2:0] K_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [2:0]  status;
    logic [9:0]  slot;
    logic [31:0] found_value;
    logic [10:0] entry_count;
  } outcome_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] key;
    logic [31:0] hash;
    logic [31:0] value;
    logic        typed;
    outcome_t    want;
  } row_t;

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [10:0] cfg_wr_data;

  ght_req_if req ();
  ght_rsp_if rsp ();

  group_probed_hash_table_top uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .req        (req),
    .rsp        (rsp)
  );

  // predictor state
  logic [7:0]  tag_mem [NSLOTS];
  logic [31:0] key_mem [NSLOTS];
  logic [31:0] val_mem [NSLOTS];
  logic [10:0] live;
  logic [10:0] fill_limit;

  outcome_t pending[$];
  int       errors;
  int       idle_cycles;
  bit       quiet;
  bit       hold_req;

  logic [31:0] pool_key  [20];
  logic [31:0] pool_hash [20];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [7:0] tag_for(input logic [31:0] h);
    logic [7:0] t;
    t = h[14:7];
    if (t >= TAG_DELETED) t = TAG_DELETED - 8'd1;
    return t;
  endfunction

  function automatic void probe_table(input logic [31:0] k, input logic [31:0] h,
                                      output int hit, output int free_s);
    int g0;
    int base;
    int first_del;
    int first_empty;
    logic [7:0] t;
    g0 = h[9:4];
    t = tag_for(h);
    first_del = NO_SLOT;
    hit = NO_SLOT;
    free_s = NO_SLOT;
    for (int n = 0; n < NGROUPS; n++) begin
      base = ((g0 + n) % NGROUPS) * GROUP_SIZE;
      first_empty = NO_SLOT;
      for (int i = 0; i < GROUP_SIZE; i++) begin
        if (tag_mem[base+i] == t && key_mem[base+i] == k) begin
          hit = base + i;
          return;
        end
      end
      for (int i = 0; i < GROUP_SIZE; i++) begin
        if (first_del == NO_SLOT && tag_mem[base+i] == TAG_DELETED) first_del = base + i;
        if (first_empty == NO_SLOT && tag_mem[base+i] == TAG_EMPTY) first_empty = base + i;
      end
      if (first_empty != NO_SLOT) begin
        free_s = (first_del != NO_SLOT) ? first_del : first_empty;
        return;
      end
    end
    free_s = first_del;
  endfunction

  function automatic outcome_t table_op(input logic [2:0] kind, input logic [31:0] k,
                                        input logic [31:0] h, input logic [31:0] v);
    outcome_t r;
    int hit;
    int free_s;
    r = '0;
    r.status = ST_NOT_FOUND;
    if (kind == K_LOOKUP || kind == K_INSERT || kind == K_ERASE || kind == K_FIND_OR_ADD) begin
      probe_table(k, h, hit, free_s);
      if (hit != NO_SLOT) begin
        r.slot = 10'(hit);
        r.found_value = val_mem[hit];
        if (kind == K_ERASE) begin
          tag_mem[hit] = TAG_DELETED;
          if (live > 0) live--;
          r.status = ST_ERASED;
        end else begin
          r.status = ST_FOUND;
        end
      end else if (kind == K_INSERT || kind == K_FIND_OR_ADD) begin
        if (kind == K_FIND_OR_ADD) v = '0;
        if (32'(live) + 1 > 32'(fill_limit) || free_s == NO_SLOT) begin
          r.status = ST_FULL;
        end else begin
          tag_mem[free_s] = tag_for(h);
          key_mem[free_s] = k;
          val_mem[free_s] = v;
          live++;
          r.status = ST_INSERTED;
          r.slot = 10'(free_s);
          r.found_value = v;
        end
      end
    end else if (kind == K_CLEAR) begin
      for (int i = 0; i < NSLOTS; i++)
        if (tag_mem[i] < TAG_DELETED) tag_mem[i] = TAG_EMPTY;
      live = '0;
      r.status = ST_CLEARED;
    end
    r.entry_count = live;
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending.size() == 0) begin
        $error("result with nothing expected: status %0d", rsp.status);
        errors++;
      end else begin
        outcome_t w;
        w = pending.pop_front();
        if (rsp.status !== w.status) begin
          $error("status: expected %0d, got %0d", w.status, rsp.status);
          errors++;
        end
        if (rsp.slot !== w.slot) begin
          $error("slot: expected %0d, got %0d", w.slot, rsp.slot);
          errors++;
        end
        if (rsp.found_value !== w.found_value) begin
          $error("found_value: expected %h, got %h", w.found_value, rsp.found_value);
          errors++;
        end
        if (rsp.entry_count !== w.entry_count) begin
          $error("entry_count: expected %0d, got %0d", w.entry_count, rsp.entry_count);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WD_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // result side back pressure
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        rsp.ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_req = 1'b0;
        rsp.ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        rsp.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        rsp.ready <= 1'b1;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  task automatic send(input logic [2:0] kind, input logic [31:0] k, input logic [31:0] h,
                      input logic [31:0] v, input logic typed = 1'b0,
                      input outcome_t want = '0);
    outcome_t p;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.kind  <= kind;
    req.key   <= k;
    req.hash  <= h;
    req.value <= v;
    // ready settles mid cycle, so look for it before the accepting edge
    @(negedge clk);
    while (!req.ready) @(negedge clk);
    @(posedge clk);
    p = table_op(kind, k, h, v);
    pending.push_back(typed ? want : p);
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_fill_limit(input logic [10:0] v);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    fill_limit = v;
  endtask

  function automatic logic [31:0] pick_hash();
    logic [14:0] lows [6];
    lows = '{15'h0000, 15'h0010, 15'h7F80, 15'h7FF0, 15'h3F8A, 15'h0385};
    return {$urandom_range(0, 3) == 0 ? 17'($urandom) : 17'd0, lows[$urandom_range(0, 5)]};
  endfunction

  task automatic random_phase(input int count);
    int j;
    int sel;
    logic [2:0] kd;
    for (int n = 0; n < count; n++) begin
      if (n == count / 2 && !quiet) hold_req = 1'b1;
      j = $urandom_range(0, 19);
      sel = $urandom_range(0, 99);
      if (sel < 35) kd = K_INSERT;
      else if (sel < 55) kd = K_LOOKUP;
      else if (sel < 75) kd = K_ERASE;
      else if (sel < 90) kd = K_FIND_OR_ADD;
      else if (sel < 93) kd = K_CLEAR;
      else kd = 3'($urandom_range(K_SPARE_LO, K_SPARE_HI));
      if ($urandom_range(0, 24) == 0)
        send(kd, $urandom, $urandom, $urandom);
      else
        send(kd, pool_key[j], pool_hash[j], $urandom);
    end
  endtask

  row_t dir [17];

  initial begin
    errors = 0;
    idle_cycles = 0;
    quiet = 1'b0;
    hold_req = 1'b0;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    req.valid = 1'b0;
    req.kind = K_LOOKUP;
    req.key = '0;
    req.hash = '0;
    req.value = '0;
    for (int i = 0; i < NSLOTS; i++) begin
      tag_mem[i] = TAG_EMPTY;
      key_mem[i] = '0;
      val_mem[i] = '0;
    end
    live = '0;
    fill_limit = 11'd768;
    for (int i = 0; i < 20; i++) begin
      pool_key[i] = (i < 4) ? 32'(i) : $urandom;
      pool_hash[i] = pick_hash();
    end

    dir = '{
      '{K_LOOKUP, 32'h0, 32'h0, 32'h0, 1'b1, '{ST_NOT_FOUND, 10'd0, 32'h0, 11'd0}},
      '{K_INSERT, 32'h0, 32'h0, 32'hFFFFFFFF, 1'b1,
        '{ST_INSERTED, 10'd0, 32'hFFFFFFFF, 11'd1}},
      '{K_INSERT, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0, 1'b1,
        '{ST_INSERTED, 10'd1008, 32'h0, 11'd2}},
      '{K_LOOKUP, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0, 1'b1,
        '{ST_FOUND, 10'd1008, 32'h0, 11'd2}},
      '{K_INSERT, 32'h0, 32'h0, 32'h5, 1'b1, '{ST_FOUND, 10'd0, 32'hFFFFFFFF, 11'd2}},
      '{K_FIND_OR_ADD, 32'h7, 32'h0, 32'h1234, 1'b1, '{ST_INSERTED, 10'd1, 32'h0, 11'd3}},
      '{K_FIND_OR_ADD, 32'h7, 32'h0, 32'h99, 1'b1, '{ST_FOUND, 10'd1, 32'h0, 11'd3}},
      '{K_ERASE, 32'h0, 32'h0, 32'h0, 1'b1, '{ST_ERASED, 10'd0, 32'hFFFFFFFF, 11'd2}},
      '{K_ERASE, 32'h0, 32'h0, 32'h0, 1'b1, '{ST_NOT_FOUND, 10'd0, 32'h0, 11'd2}},
      '{K_INSERT, 32'h9, 32'h0, 32'h1, 1'b1, '{ST_INSERTED, 10'd0, 32'h1, 11'd3}},
      '{K_INSERT, 32'hA5A5, 32'h00003F80, 32'h77, 1'b0, '0},
      '{K_LOOKUP, 32'h5A5A, 32'h00003F80, 32'h0, 1'b0, '0},
      '{K_ERASE, 32'h7, 32'h0, 32'h0, 1'b1, '{ST_ERASED, 10'd1, 32'h0, 11'd3}},
      '{K_SPARE_LO, 32'h9, 32'h0, 32'h0, 1'b1, '{ST_NOT_FOUND, 10'd0, 32'h0, 11'd3}},
      '{K_SPARE_HI, 32'h9, 32'h0, 32'h0, 1'b1, '{ST_NOT_FOUND, 10'd0, 32'h0, 11'd3}},
      '{K_CLEAR, 32'h0, 32'h0, 32'h0, 1'b1, '{ST_CLEARED, 10'd0, 32'h0, 11'd0}},
      '{K_INSERT, 32'h3, 32'h0, 32'h3, 1'b1, '{ST_INSERTED, 10'd1, 32'h3, 11'd1}}
    };

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (dir[i])
      send(dir[i].kind, dir[i].key, dir[i].hash, dir[i].value, dir[i].typed, dir[i].want);

    // fill limit at its low extreme: new keys refused, present keys still found
    set_fill_limit(11'd0);
    send(K_INSERT, 32'h44, 32'h0, 32'h4, 1'b1, '{ST_FULL, 10'd0, 32'h0, 11'd1});
    send(K_FIND_OR_ADD, 32'h3, 32'h0, 32'h0, 1'b1, '{ST_FOUND, 10'd1, 32'h3, 11'd1});
    set_fill_limit(11'd5);
    random_phase(80);

    // fill to the limit from one start group, so scans run across full groups
    set_fill_limit(11'd128);
    send(K_CLEAR, 32'h0, 32'h0, 32'h0);
    for (int i = 0; i < 132; i++)
      send(K_INSERT, 32'h10000000 + i, {17'($urandom), 15'h0}, $urandom);
    send(K_LOOKUP, 32'hDEADBEEF, 32'h0, 32'h0);
    for (int i = 0; i < 6; i++)
      send(K_ERASE, 32'h10000000 + 3 * i, 32'h0, 32'h0);
    for (int i = 0; i < 6; i++)
      send(K_INSERT, 32'h20000000 + i, {17'($urandom), 15'h0}, $urandom);

    set_fill_limit(11'd2047);
    send(K_CLEAR, 32'h0, 32'h0, 32'h0);
    random_phase(80);
    set_fill_limit(11'd12);
    random_phase(60);
    quiet = 1'b1;
    random_phase(40);

    drain();
    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
